// File: hdl/gsfa_pkg.sv
// gsfa_pkg: shared types, codes and helper functions of the gas sensor framer
// and alarm block; no dependencies, compiled first
`timescale 1ns / 1ps

package gsfa_pkg;

   // default reply length in bytes
   localparam int FRAME_BYTES_DEF = 7;

   // crc-16/modbus constants
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // configuration register defaults
   localparam logic [7:0]  DEVICE_ADDRESS_RST   = 8'd1;
   localparam logic [15:0] WARN_THRESHOLD_RST   = 16'd21;
   localparam logic [15:0] DANGER_THRESHOLD_RST = 16'd41;
   localparam logic [7:0]  BEEP_DELAY_RST       = 8'd20;

   localparam int CSR_DATA_W = 16;

   // item kinds on the request channel
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS   = 2'd0,
      CSR_WARN_THRESHOLD   = 2'd1,
      CSR_DANGER_THRESHOLD = 2'd2,
      CSR_BEEP_DELAY       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      RX_GOOD      = 3'd0,
      RX_NO_BYTE   = 3'd1,
      RX_BAD_HEAD  = 3'd2,
      RX_SHORT     = 3'd3,
      RX_CRC_ERROR = 3'd4
   } rx_status_type;

   typedef enum logic [1:0] {
      ALARM_SAFE   = 2'd0,
      ALARM_WARN   = 2'd1,
      ALARM_DANGER = 2'd2
   } alarm_level_type;

   typedef enum logic [1:0] {
      SOUND_SILENCE = 2'd0,
      SOUND_DOUBLE  = 2'd1,
      SOUND_QUAD    = 2'd2
   } sound_kind_type;

   typedef enum logic [1:0] {
      FAN_NONE  = 2'd0,
      FAN_OPEN  = 2'd1,
      FAN_CLOSE = 2'd2
   } fan_action_type;

   // upper bounds of the display steps
   localparam logic [15:0] LEVEL_STEPS [8] = '{
      16'd12, 16'd16, 16'd20, 16'd28, 16'd35, 16'd40, 16'd48, 16'd100
   };

   // one byte through the reflected crc, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_old,
                                            input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_old ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // first step whose bound is not below the reading, else the top step
   function automatic logic [3:0] level_of(input logic [15:0] value);
      logic [3:0] lvl;
      lvl = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (value <= LEVEL_STEPS[i]) begin
            lvl = 4'(i);
         end
      end
      return lvl;
   endfunction

endpackage

// File: hdl/gsfa_if.sv
// gsfa_if: valid/ready channel interfaces for the request and result sides
// of the gas sensor framer; no dependencies
`timescale 1ns / 1ps

// request channel: reply bytes and poll ticks
interface gsfa_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   logic       power_on;

   modport source (output valid, output action, output rx_byte, output power_on,
                   input ready);
   modport sink (input valid, input action, input rx_byte, input power_on,
                 output ready);
endinterface

// result channel: one item per poll tick
interface gsfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] concentration;
   logic [3:0]  display_level;
   logic [2:0]  rx_status;
   logic [1:0]  alarm_level;
   logic        sound_valid;
   logic [1:0]  sound_kind;
   logic        sound_speak;
   logic [1:0]  fan_action;

   modport source (output valid, output concentration, output display_level,
                   output rx_status, output alarm_level, output sound_valid,
                   output sound_kind, output sound_speak, output fan_action,
                   input ready);
   modport sink (input valid, input concentration, input display_level,
                 input rx_status, input alarm_level, input sound_valid,
                 input sound_kind, input sound_speak, input fan_action,
                 output ready);
endinterface

// File: hdl/gas_sensor_frame_and_alarm.sv
// gas_sensor_frame_and_alarm: reply framer with crc check, display level and
// alarm machine; depends on gsfa_pkg and the channel interfaces in gsfa_if
`timescale 1ns / 1ps

// Takes one request transfer per clock: a reply byte (action 0) or a poll
// tick (action 1). The first byte is checked against the device address;
// bytes go into a CRC-16/MODBUS, concentration bytes kept; a byte transfer
// gives no result. A tick closes the frame and gives exactly one result
// transfer with the stored concentration, its 9-step display level, the
// frame status and the alarm machine's sound and fan commands. The block
// sustains one transfer per cycle while not stalled; a tick is held in the
// input register and then loads the result register, from which the
// result is offered. The longest paths are the eight-step CRC byte
// update and the alarm rule chain, both combinational. The request side
// stalls only while a result waits on the response side and another tick
// stands in the input register.
module gas_sensor_frame_and_alarm
   import gsfa_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gsfa_req_if.sink              req_chan,
   gsfa_rsp_if.source            rsp_chan,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] FRAME_LEN    = 3'(FRAME_BYTES);
   localparam logic [2:0] CRC_LOW_IDX  = 3'(FRAME_BYTES - 2);
   localparam logic [2:0] HIGH_IDX     = 3'd3;
   localparam logic [2:0] LOW_IDX      = 3'd4;

   // configuration registers
   logic [7:0]  device_address_ff;
   logic [15:0] warn_threshold_ff;
   logic [15:0] danger_threshold_ff;
   logic [7:0]  beep_delay_ff;

   // input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;
   logic       in_power_ff;

   // frame and alarm state
   logic [2:0]      byte_count_ff, byte_count_in;
   logic            head_bad_ff, head_bad_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      value_high_ff, value_high_in;
   logic [7:0]      value_low_ff, value_low_in;
   logic [7:0]      crc_low_ff, crc_low_in;
   logic [15:0]     reading_ff, reading_in;
   alarm_level_type now_level_ff, now_level_in;
   alarm_level_type prior_level_ff, prior_level_in;
   logic [7:0]      delay_ff, delay_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_conc_ff;
   logic [3:0]      rsp_disp_ff;
   rx_status_type   rsp_status_ff, status_in;
   alarm_level_type rsp_alarm_ff;
   logic            rsp_svalid_ff, svalid_in;
   sound_kind_type  rsp_kind_ff, kind_in;
   logic            rsp_speak_ff, speak_in;
   fan_action_type  rsp_fan_ff, fan_in;

   logic advance;
   logic tick_done;

   // the held item moves on unless it is a tick and the result slot stays full
   assign advance   = in_valid_ff &&
                      (in_action_ff == ACTION_BYTE || !rsp_valid_ff || rsp_chan.ready);
   assign tick_done = advance && (in_action_ff == ACTION_TICK);
   assign req_chan.ready = !in_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff   <= DEVICE_ADDRESS_RST;
         warn_threshold_ff   <= WARN_THRESHOLD_RST;
         danger_threshold_ff <= DANGER_THRESHOLD_RST;
         beep_delay_ff       <= BEEP_DELAY_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS:   device_address_ff   <= csr_wdata[7:0];
            CSR_WARN_THRESHOLD:   warn_threshold_ff   <= csr_wdata[15:0];
            CSR_DANGER_THRESHOLD: danger_threshold_ff <= csr_wdata[15:0];
            CSR_BEEP_DELAY:       beep_delay_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_action_ff <= req_chan.action;
         in_byte_ff   <= req_chan.rx_byte;
         in_power_ff  <= req_chan.power_on;
      end
   end

   // frame assembly, status and alarm rules for the held item
   always_comb begin
      logic [15:0] rd;
      byte_count_in  = byte_count_ff;
      head_bad_in    = head_bad_ff;
      crc_in         = crc_ff;
      value_high_in  = value_high_ff;
      value_low_in   = value_low_ff;
      crc_low_in     = crc_low_ff;
      reading_in     = reading_ff;
      now_level_in   = now_level_ff;
      prior_level_in = prior_level_ff;
      delay_in       = delay_ff;
      status_in      = RX_GOOD;
      svalid_in      = 1'b0;
      kind_in        = SOUND_SILENCE;
      speak_in       = 1'b0;
      fan_in         = FAN_NONE;
      rd             = reading_ff;

      if (advance && in_action_ff == ACTION_BYTE) begin
         // reply byte: ignored after a bad head or a full frame
         if (!head_bad_ff && byte_count_ff < FRAME_LEN) begin
            if (byte_count_ff == 3'd0) begin
               value_high_in = 8'h00;
               value_low_in  = 8'h00;
               if (in_byte_ff != device_address_ff) begin
                  head_bad_in = 1'b1;
               end
            end
            if (byte_count_ff == HIGH_IDX) begin
               value_high_in = in_byte_ff;
            end
            if (byte_count_ff == LOW_IDX) begin
               value_low_in = in_byte_ff;
            end
            if (byte_count_ff < CRC_LOW_IDX) begin
               crc_in = crc_byte(crc_ff, in_byte_ff);
            end else if (byte_count_ff == CRC_LOW_IDX) begin
               crc_low_in = in_byte_ff;
            end else begin
               crc_in = crc_ff ^ {in_byte_ff, crc_low_ff};
            end
            byte_count_in = byte_count_ff + 3'd1;
         end
      end else if (tick_done) begin
         // frame status
         if (byte_count_ff == 3'd0) begin
            status_in = RX_NO_BYTE;
         end else if (head_bad_ff) begin
            status_in = RX_BAD_HEAD;
         end else if (byte_count_ff < FRAME_LEN) begin
            status_in = RX_SHORT;
         end else if (crc_ff != 16'h0000) begin
            status_in = RX_CRC_ERROR;
         end else begin
            status_in = RX_GOOD;
            rd        = {value_high_ff, value_low_ff};
         end
         reading_in    = rd;
         byte_count_in = 3'd0;
         head_bad_in   = 1'b0;
         crc_in        = CRC_INIT;

         if (!in_power_ff) begin
            // power off: silence and close, levels kept
            delay_in  = 8'h00;
            svalid_in = 1'b1;
            kind_in   = SOUND_SILENCE;
            fan_in    = FAN_CLOSE;
         end else begin
            // safe rule
            if (rd < warn_threshold_ff) begin
               if (now_level_in != ALARM_SAFE) begin
                  delay_in       = 8'h00;
                  now_level_in   = ALARM_SAFE;
                  prior_level_in = ALARM_SAFE;
                  svalid_in      = 1'b1;
                  kind_in        = SOUND_SILENCE;
                  speak_in       = 1'b0;
                  fan_in         = FAN_CLOSE;
               end
            end
            // warning rule, steps see each other's updates
            if (rd >= warn_threshold_ff && rd < danger_threshold_ff) begin
               if (now_level_in == ALARM_SAFE && prior_level_in == ALARM_SAFE) begin
                  now_level_in = ALARM_WARN;
                  delay_in     = 8'h00;
                  svalid_in    = 1'b1;
                  kind_in      = SOUND_SILENCE;
                  speak_in     = 1'b1;
                  fan_in       = FAN_OPEN;
               end
               if (now_level_in == ALARM_WARN && prior_level_in == ALARM_SAFE) begin
                  if (delay_in >= beep_delay_ff) begin
                     delay_in       = 8'h00;
                     svalid_in      = 1'b1;
                     kind_in        = SOUND_DOUBLE;
                     prior_level_in = ALARM_WARN;
                  end else begin
                     delay_in = delay_in + 8'd1;
                  end
               end
               if (now_level_in == ALARM_DANGER && prior_level_in == ALARM_DANGER) begin
                  now_level_in   = ALARM_WARN;
                  svalid_in      = 1'b1;
                  kind_in        = SOUND_DOUBLE;
                  prior_level_in = ALARM_WARN;
               end
               if (now_level_in == ALARM_WARN && prior_level_in == ALARM_DANGER) begin
                  prior_level_in = ALARM_WARN;
               end
            end
            // danger rule
            if (rd >= danger_threshold_ff) begin
               if (now_level_in == ALARM_SAFE || now_level_in == ALARM_WARN) begin
                  delay_in  = 8'h00;
                  svalid_in = 1'b1;
                  kind_in   = SOUND_QUAD;
                  if (now_level_in == ALARM_SAFE && prior_level_in == ALARM_SAFE) begin
                     speak_in = 1'b1;
                  end
                  now_level_in   = ALARM_DANGER;
                  prior_level_in = ALARM_DANGER;
                  fan_in         = FAN_OPEN;
               end
            end
         end
      end
   end

   // frame and alarm state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 3'd0;
         head_bad_ff    <= 1'b0;
         crc_ff         <= CRC_INIT;
         value_high_ff  <= 8'h00;
         value_low_ff   <= 8'h00;
         crc_low_ff     <= 8'h00;
         reading_ff     <= 16'h0000;
         now_level_ff   <= ALARM_SAFE;
         prior_level_ff <= ALARM_SAFE;
         delay_ff       <= 8'h00;
      end else begin
         byte_count_ff  <= byte_count_in;
         head_bad_ff    <= head_bad_in;
         crc_ff         <= crc_in;
         value_high_ff  <= value_high_in;
         value_low_ff   <= value_low_in;
         crc_low_ff     <= crc_low_in;
         reading_ff     <= reading_in;
         now_level_ff   <= now_level_in;
         prior_level_ff <= prior_level_in;
         delay_ff       <= delay_in;
      end
   end

   // result register: held until the transfer, reloaded on a tick
   assign rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || tick_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_done) begin
         rsp_conc_ff   <= reading_in;
         rsp_disp_ff   <= level_of(reading_in);
         rsp_status_ff <= status_in;
         rsp_alarm_ff  <= now_level_in;
         rsp_svalid_ff <= svalid_in;
         rsp_kind_ff   <= svalid_in ? kind_in : SOUND_SILENCE;
         rsp_speak_ff  <= svalid_in && speak_in;
         rsp_fan_ff    <= fan_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.concentration = rsp_conc_ff;
   assign rsp_chan.display_level = rsp_disp_ff;
   assign rsp_chan.rx_status     = rsp_status_ff;
   assign rsp_chan.alarm_level   = rsp_alarm_ff;
   assign rsp_chan.sound_valid   = rsp_svalid_ff;
   assign rsp_chan.sound_kind    = rsp_kind_ff;
   assign rsp_chan.sound_speak   = rsp_speak_ff;
   assign rsp_chan.fan_action    = rsp_fan_ff;

`ifndef NO_ASSERTIONS
   // byte counter stops at a full frame
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= FRAME_LEN)
      else $error("byte count ran past the frame length");

   // a bad head is only flagged once a byte has been counted
   assert property (@(posedge clock) disable iff (reset)
      head_bad_ff |-> byte_count_ff != 3'd0)
      else $error("bad head flag without a counted byte");

   // safe level always comes with a cleared prior level
   assert property (@(posedge clock) disable iff (reset)
      now_level_ff == ALARM_SAFE |-> prior_level_ff == ALARM_SAFE)
      else $error("safe level with a stale prior level");

   // no sound command means silent, non-spoken fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_svalid_ff) |-> (rsp_kind_ff == SOUND_SILENCE && !rsp_speak_ff))
      else $error("sound fields set without a sound command");

   // a tick with power off yields a result that closes the fan
   assert property (@(posedge clock) disable iff (reset)
      (tick_done && !in_power_ff) |=> (rsp_valid_ff && rsp_fan_ff == FAN_CLOSE))
      else $error("power off tick did not close the fan");
`endif

endmodule
